>>> hdl/vdi_pkg.sv
// Shared types and constants for the vertex deduplication indexer.
package vdi_pkg;

    localparam int unsigned KEY_LEN   = 8;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned KEY_W     = KEY_LEN * WORD_W;
    localparam int unsigned INDEX_W   = 10;
    localparam int unsigned MODE_W    = 2;

    localparam logic [MODE_W-1:0] MODE_POS     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POS_TEX = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FULL    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET   = MODE_FULL;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_CMP   = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    // Result fields handed from the sequencer to the output register.
    typedef struct packed {
        logic               valid;
        logic [INDEX_W-1:0] index;
        logic               is_new;
        logic               overflow;
    } result_t;

endpackage

>>> hdl/vertex_dedup_indexer.sv
// Vertex deduplication indexer: one item at a time; busy is high once an item
// is accepted and through the result strobe cycle, so the next item is accepted
// in the cycle after the strobe at the earliest. Entries are scanned one per cycle
// through the key memory read port. Reset clears the entry count and sets
// attribute_mode to 2; the key memory needs no clearing. Results cannot be
// stalled by the receiver.
module vertex_dedup_indexer #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic        start_of_mesh,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [31:0] tex_u,
    input  logic [31:0] tex_v,
    input  logic [31:0] normal_x,
    input  logic [31:0] normal_y,
    input  logic [31:0] normal_z,
    output logic        result_valid,
    output logic [9:0]  vertex_index,
    output logic        is_new,
    output logic        overflow
);

    localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    vdi_pkg::state_t state_reg, state_next;
    logic [vdi_pkg::MODE_W-1:0] mode_reg;
    logic [vdi_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           scan_reg, scan_next;
    vdi_pkg::result_t           res_reg, res_next;
    logic [vdi_pkg::KEY_W-1:0]  rd_data;
    logic                       rd_en, wr_en;
    logic [ADDR_W-1:0]          rd_addr, wr_addr;
    logic                       accept;

    assign accept = start && !busy;
    assign busy   = (state_reg != vdi_pkg::ST_IDLE);

    vdi_key_mem #(.DEPTH(TABLE_DEPTH), .ADDR_W(ADDR_W)) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (key_reg)
    );

    assign wr_addr = count_reg[ADDR_W-1:0];

    // Sequence lookup: read entry, compare, advance or store
    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        res_next   = '0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        rd_addr    = scan_reg[ADDR_W-1:0];
        unique case (state_reg)
            vdi_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    key_next[0*32 +: 32] = pos_x;
                    key_next[1*32 +: 32] = pos_y;
                    key_next[2*32 +: 32] = pos_z;
                    key_next[3*32 +: 32] = (mode_reg != vdi_pkg::MODE_POS) ? tex_u : 32'd0;
                    key_next[4*32 +: 32] = (mode_reg != vdi_pkg::MODE_POS) ? tex_v : 32'd0;
                    key_next[5*32 +: 32] = (mode_reg[1]) ? normal_x : 32'd0;
                    key_next[6*32 +: 32] = (mode_reg[1]) ? normal_y : 32'd0;
                    key_next[7*32 +: 32] = (mode_reg[1]) ? normal_z : 32'd0;
                    if (start_of_mesh)
                    begin
                        count_next = '0;
                    end
                    scan_next  = '0;
                    state_next = vdi_pkg::ST_READ;
                end
            end
            vdi_pkg::ST_READ:
            begin
                if (scan_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = vdi_pkg::ST_CMP;
                end
                else
                begin
                    state_next = vdi_pkg::ST_WRITE;
                end
            end
            vdi_pkg::ST_CMP:
            begin
                if (rd_data == key_reg)
                begin
                    res_next.valid = 1'b1;
                    res_next.index = vdi_pkg::INDEX_W'(scan_reg);
                    state_next     = vdi_pkg::ST_DONE;
                end
                else if (scan_reg + CNT_W'(1) < count_reg)
                begin
                    // Read next entry while this one is compared
                    scan_next  = scan_reg + CNT_W'(1);
                    rd_en      = 1'b1;
                    rd_addr    = scan_next[ADDR_W-1:0];
                    state_next = vdi_pkg::ST_CMP;
                end
                else
                begin
                    state_next = vdi_pkg::ST_WRITE;
                end
            end
            vdi_pkg::ST_WRITE:
            begin
                res_next.valid = 1'b1;
                if (count_reg >= DEPTH_C)
                begin
                    res_next.overflow = 1'b1;
                end
                else
                begin
                    wr_en           = 1'b1;
                    res_next.is_new = 1'b1;
                    res_next.index  = vdi_pkg::INDEX_W'(count_reg);
                    count_next      = count_reg + CNT_W'(1);
                end
                state_next = vdi_pkg::ST_DONE;
            end
            vdi_pkg::ST_DONE:
            begin
                state_next = vdi_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = vdi_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vdi_pkg::ST_IDLE;
            mode_reg  <= vdi_pkg::MODE_RESET;
            count_reg <= '0;
            scan_reg  <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
            res_reg   <= res_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    // Hold key of the item in work
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign result_valid = res_reg.valid;
    assign vertex_index = res_reg.index;
    assign is_new       = res_reg.is_new;
    assign overflow     = res_reg.overflow;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count beyond table depth");
    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(is_new && overflow))
        else $error("new and overflow together");
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_next.valid |-> busy)
        else $error("result while idle");
    a_store_new: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (result_valid && is_new))
        else $error("store without new result");
`endif

endmodule

>>> hdl/vdi_key_mem.sv
// Key store: one full key per entry, with a registered synchronous read.
module vdi_key_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned ADDR_W = 10
) (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [vdi_pkg::KEY_W-1:0] rd_data,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [vdi_pkg::KEY_W-1:0] wr_data
);

    logic [vdi_pkg::KEY_W-1:0] mem [DEPTH];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> test/vertex_dedup_indexer_tb.sv
// Self-checking testbench for the vertex deduplication indexer.
module vertex_dedup_indexer_tb;

    localparam int unsigned DEPTH = 1024;
    localparam logic [vdi_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic                                som;
        logic [vdi_pkg::KEY_LEN-1:0][31:0]   w;   // 0..2 position, 3..4 texcoord, 5..7 normal
    } vertex_t;

    typedef struct packed {
        logic [vdi_pkg::INDEX_W-1:0] index;
        logic                        is_new;
        logic                        overflow;
    } lookup_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [vdi_pkg::MODE_W-1:0] cfg_wdata;
    logic start;
    logic busy;
    logic start_of_mesh;
    logic [31:0] pos_x, pos_y, pos_z, tex_u, tex_v, normal_x, normal_y, normal_z;
    logic result_valid;
    logic [9:0] vertex_index;
    logic is_new;
    logic overflow;

    vertex_dedup_indexer u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .start(start), .busy(busy), .start_of_mesh(start_of_mesh),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tex_u(tex_u), .tex_v(tex_v),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .result_valid(result_valid), .vertex_index(vertex_index),
        .is_new(is_new), .overflow(overflow)
    );

    // Mirror of the block's table and mode
    logic [vdi_pkg::KEY_W-1:0]  known_keys [DEPTH];
    int unsigned                known_count;
    logic [vdi_pkg::MODE_W-1:0] cur_mode;

    vertex_t     pending_vertices[$];
    lookup_t     expected_lookups[$];
    int unsigned send_gap_pct;
    int unsigned errors, n_new, n_hit, n_ovf;

    // Look a vertex up in the mirrored table and update it
    function automatic lookup_t dedup_lookup(vertex_t v);
        logic [vdi_pkg::KEY_LEN-1:0][31:0] key;
        lookup_t r;
        key = v.w;
        if (v.som)
            known_count = 0;
        if (cur_mode == vdi_pkg::MODE_POS)
            for (int k = 3; k < vdi_pkg::KEY_LEN; k++) key[k] = '0;
        else if (cur_mode == vdi_pkg::MODE_POS_TEX)
            for (int k = 5; k < vdi_pkg::KEY_LEN; k++) key[k] = '0;
        for (int e = 0; e < known_count; e++) begin
            if (known_keys[e] == key) begin
                r.index = e[vdi_pkg::INDEX_W-1:0];
                r.is_new = 1'b0;
                r.overflow = 1'b0;
                return r;
            end
        end
        if (known_count >= DEPTH) begin
            r = '0;
            r.overflow = 1'b1;
            return r;
        end
        known_keys[known_count] = key;
        r.index = known_count[vdi_pkg::INDEX_W-1:0];
        r.is_new = 1'b1;
        r.overflow = 1'b0;
        known_count++;
        return r;
    endfunction

    // Clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Driver: present the oldest pending item, predict it on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        logic nstart;
        if (!rst_n)
        begin
            start <= 1'b0;
            start_of_mesh <= 1'b0;
            {pos_x, pos_y, pos_z, tex_u, tex_v, normal_x, normal_y, normal_z} <= '0;
        end
        else
        begin
            nstart = start;
            if (start && !busy)
            begin
                expected_lookups.insert(expected_lookups.size(),
                                        dedup_lookup(pending_vertices.pop_front()));
                nstart = 1'b0;
            end
            if (!nstart && pending_vertices.size() > 0 &&
                $urandom_range(99) >= send_gap_pct)
            begin
                start_of_mesh <= pending_vertices[0].som;
                pos_x    <= pending_vertices[0].w[0];
                pos_y    <= pending_vertices[0].w[1];
                pos_z    <= pending_vertices[0].w[2];
                tex_u    <= pending_vertices[0].w[3];
                tex_v    <= pending_vertices[0].w[4];
                normal_x <= pending_vertices[0].w[5];
                normal_y <= pending_vertices[0].w[6];
                normal_z <= pending_vertices[0].w[7];
                nstart = 1'b1;
            end
            start <= nstart;
        end
    end

    // Monitor: compare each result strobe with the oldest expectation
    always @(posedge clk)
    begin
        lookup_t x;
        if (rst_n && result_valid)
        begin
            if (expected_lookups.size() == 0)
            begin
                $display("%0t: unexpected result index=%0d new=%0b ovf=%0b",
                         $time, vertex_index, is_new, overflow);
                errors++;
            end
            else
            begin
                x = expected_lookups.pop_front();
                if (vertex_index !== x.index)
                begin
                    $display("%0t: vertex_index expected %0d actual %0d",
                             $time, x.index, vertex_index);
                    errors++;
                end
                if (is_new !== x.is_new)
                begin
                    $display("%0t: is_new expected %0b actual %0b", $time, x.is_new, is_new);
                    errors++;
                end
                if (overflow !== x.overflow)
                begin
                    $display("%0t: overflow expected %0b actual %0b",
                             $time, x.overflow, overflow);
                    errors++;
                end
                if (x.overflow) n_ovf++;
                else if (x.is_new) n_new++;
                else n_hit++;
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'h7FC0_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic vertex_t rand_vertex(logic som);
        vertex_t v;
        v.som = som;
        for (int k = 0; k < vdi_pkg::KEY_LEN; k++) v.w[k] = rand_word();
        return v;
    endfunction

    task automatic push_vertex(logic som, logic [vdi_pkg::KEY_LEN-1:0][31:0] w);
        vertex_t v;
        v.som = som;
        v.w = w;
        pending_vertices.insert(pending_vertices.size(), v);
    endtask

    // Wait for all items to be checked and the block to go idle
    task automatic drain();
        while (pending_vertices.size() > 0 || expected_lookups.size() > 0 || start || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_mode(logic [vdi_pkg::MODE_W-1:0] m);
        drain();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_mode = m;
    endtask

    // Meshes drawn from small vertex pools, so most lookups hit
    task automatic gen_meshes(int unsigned n_items);
        vertex_t pool[$];
        vertex_t v;
        int unsigned sent, len;
        sent = 0;
        while (sent < n_items)
        begin
            pool.delete();
            repeat ($urandom_range(24, 1)) pool.insert(pool.size(), rand_vertex(1'b0));
            len = $urandom_range(60, 5);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(99) < 8)
                    v = rand_vertex(1'b0);
                else
                begin
                    v = pool[$urandom_range(pool.size() - 1)];
                    // perturb words the current mode ignores
                    if ($urandom_range(1))
                    begin
                        if (cur_mode == vdi_pkg::MODE_POS)
                            for (int k = 3; k < vdi_pkg::KEY_LEN; k++) v.w[k] = $urandom;
                        else if (cur_mode == vdi_pkg::MODE_POS_TEX)
                            for (int k = 5; k < vdi_pkg::KEY_LEN; k++) v.w[k] = $urandom;
                    end
                end
                v.som = (i == 0) || ($urandom_range(99) < 2);
                pending_vertices.insert(pending_vertices.size(), v);
            end
            sent += len;
        end
    endtask

    initial
    begin
        logic [vdi_pkg::KEY_LEN-1:0][31:0] w;
        errors = 0; n_new = 0; n_hit = 0; n_ovf = 0;
        known_count = 0;
        cur_mode = vdi_pkg::MODE_RESET;
        send_gap_pct = 0;
        cfg_we = 1'b0;
        cfg_wdata = vdi_pkg::MODE_RESET;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset mode: zeros, ones, signed zero, NaN, table clear
        push_vertex(1'b1, '0);
        push_vertex(1'b0, '0);
        push_vertex(1'b0, '1);
        w = '0; w[0] = 32'h8000_0000;
        push_vertex(1'b0, w);
        w = '0; w[1] = 32'h7FC0_0000; w[7] = 32'h7FC0_0000;
        push_vertex(1'b0, w);
        push_vertex(1'b0, w);
        push_vertex(1'b1, '1);
        push_vertex(1'b0, '0);

        // Mode three behaves as full key: normal alone separates vertices
        set_mode(MODE_SPARE);
        w = '0; w[5] = 32'h3F80_0000;
        push_vertex(1'b1, '0);
        push_vertex(1'b0, w);
        push_vertex(1'b0, w);

        // Position only: texcoord and normal are ignored
        set_mode(vdi_pkg::MODE_POS);
        w = '0; w[3] = 32'hDEAD_BEEF; w[6] = 32'h1234_5678;
        push_vertex(1'b1, '0);
        push_vertex(1'b0, w);

        // Position and texcoord: normal ignored, texcoord counts
        set_mode(vdi_pkg::MODE_POS_TEX);
        push_vertex(1'b1, w);
        w[7] = 32'hFFFF_FFFF;
        push_vertex(1'b0, w);
        w[4] = 32'h0000_0001;
        push_vertex(1'b0, w);

        // Fill the table, then overflow and hit at both ends
        set_mode(vdi_pkg::MODE_POS);
        for (int i = 0; i < DEPTH; i++)
        begin
            w = '0;
            w[0] = i;
            w[2] = $urandom;
            w[4] = $urandom;
            push_vertex(i == 0, w);
        end
        w = '1;
        push_vertex(1'b0, w);
        push_vertex(1'b0, w);
        w = '0; w[1] = 32'h8000_0000;
        push_vertex(1'b0, w);
        push_vertex(1'b0, pending_vertices[DEPTH - 1].w);
        push_vertex(1'b0, pending_vertices[0].w);

        // Random meshes across modes and sender gap phases
        set_mode(vdi_pkg::MODE_FULL);
        send_gap_pct = 0;
        gen_meshes(200);
        set_mode(vdi_pkg::MODE_POS);
        send_gap_pct = 50;
        gen_meshes(200);
        set_mode(vdi_pkg::MODE_POS_TEX);
        send_gap_pct = 7;
        gen_meshes(200);
        set_mode(MODE_SPARE);
        send_gap_pct = 0;
        gen_meshes(200);

        drain();
        repeat (10) @(posedge clk);
        $display("Checked %0d results: %0d new, %0d hits, %0d overflows,",
                 n_new + n_hit + n_ovf, n_new, n_hit, n_ovf);
        $display("over all attribute modes with a full-table fill and sender gaps.");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Timeout
    initial
    begin
        #8000000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> vertex_dedup_indexer.f
hdl/vdi_pkg.sv
hdl/vdi_key_mem.sv
hdl/vertex_dedup_indexer.sv
test/vertex_dedup_indexer_tb.sv
